### hw/rtl/gear_event_ring_logger_defines.svh
// Assertion macros used by the gear event ring logger datapath.
`ifndef GEAR_EVENT_RING_LOGGER_DEFINES_SVH
`define GEAR_EVENT_RING_LOGGER_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define GERL_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define GERL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gerl_pkg.sv
// Package: types, codes, defaults and helpers for the gear event ring logger.
package gerl_pkg;

	localparam int LOG_DEPTH_DEF = 10;
	localparam int TOP_GEAR_DEF  = 6;

	localparam logic       OP_SAMPLE = 1'b0;
	localparam logic       OP_READ   = 1'b1;
	localparam logic [1:0] KEY_UP    = 2'd1;
	localparam logic [1:0] KEY_DOWN  = 2'd2;

	localparam int SPEED_SCALE = 100;
	localparam int ADC_FULL    = 1023;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	// tens*10 + units, digits above nine are taken as they stand
	function automatic logic [7:0] bcd_to_bin(input logic [3:0] tens, input logic [3:0] units);
		return (8'(tens) * 8'd10) + 8'(units);
	endfunction

endpackage

### hw/rtl/gerl_ctrl.sv
// Controller: sequences capture, execute and result transfer of one item.
module gerl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output gerl_pkg::cmd_t cmd
);
	import gerl_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (!out_stall) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

### hw/rtl/gerl_dpath.sv
// Datapath: gear state, speed scaling, BCD conversion and the record ring.
module gerl_dpath #(
	parameter int LOG_DEPTH = gerl_pkg::LOG_DEPTH_DEF,
	parameter int TOP_GEAR  = gerl_pkg::TOP_GEAR_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gerl_pkg::cmd_t cmd,
	input  logic           operation,
	input  logic [1:0]     key_event,
	input  logic [7:0]     hours_bcd,
	input  logic [7:0]     minutes_bcd,
	input  logic [7:0]     seconds_bcd,
	input  logic [9:0]     speed_sample,
	input  logic [3:0]     read_slot,
	output logic [2:0]     current_gear,
	output logic [6:0]     current_speed,
	output logic           record_written,
	output logic           record_valid,
	output logic [5:0]     rec_hours,
	output logic [7:0]     rec_minutes,
	output logic [7:0]     rec_seconds,
	output logic [6:0]     rec_speed,
	output logic [2:0]     rec_gear,
	output logic [4:0]     stored_count,
	output logic [3:0]     next_slot
);
	import gerl_pkg::*;
	`include "gear_event_ring_logger_defines.svh"

	localparam int PTR_W = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	// captured item
	logic        op_q;
	logic [1:0]  key_q;
	logic [7:0]  hours_q;
	logic [7:0]  minutes_q;
	logic [7:0]  seconds_q;
	logic [16:0] prod_q;
	logic [3:0]  slot_q;

	// control state
	logic [2:0]       gear_q;
	logic [2:0]       gear_logged_q;
	logic [PTR_W-1:0] wptr_q;
	logic [CNT_W-1:0] count_q;

	// result
	logic [6:0]  speed_q;
	logic        written_q;
	logic        valid_q;
	logic [31:0] rd_word_q;

	logic [31:0] mem_q [LOG_DEPTH];

	logic [2:0]  gear_nxt;
	logic [6:0]  quot_est;
	logic [10:0] rem_est;
	logic [6:0]  speed_nxt;
	logic [5:0]  hh;
	logic [7:0]  mm;
	logic [7:0]  ss;
	logic [31:0] word_nxt;
	logic        wr_en;
	logic        rd_hit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= operation;
			key_q     <= key_event;
			hours_q   <= hours_bcd;
			minutes_q <= minutes_bcd;
			seconds_q <= seconds_bcd;
			prod_q    <= 17'(speed_sample) * 17'(SPEED_SCALE);
			slot_q    <= read_slot;
		end
	end

	always_comb begin
		gear_nxt = gear_q;
		if (op_q == OP_SAMPLE) begin
			priority if (key_q == KEY_UP && gear_q < 3'(TOP_GEAR)) begin
				gear_nxt = gear_q + 3'd1;
			end else if (key_q == KEY_DOWN && gear_q != 3'd0) begin
				gear_nxt = gear_q - 3'd1;
			end else begin
				gear_nxt = gear_q;
			end
		end
	end

	// x/1023: estimate x>>10, remainder is (x mod 1024) + estimate, below 2*1023
	assign quot_est  = prod_q[16:10];
	assign rem_est   = {1'b0, prod_q[9:0]} + 11'(quot_est);
	assign speed_nxt = quot_est + ((rem_est >= 11'(ADC_FULL)) ? 7'd1 : 7'd0);

	assign hh = 6'(bcd_to_bin({2'b00, hours_q[5:4]}, hours_q[3:0]));
	assign mm = bcd_to_bin(minutes_q[7:4], minutes_q[3:0]);
	assign ss = bcd_to_bin(seconds_q[7:4], seconds_q[3:0]);
	assign word_nxt = {gear_nxt, speed_nxt, ss, mm, hh};

	assign wr_en  = (op_q == OP_SAMPLE) && (gear_nxt != gear_logged_q);
	assign rd_hit = (op_q == OP_READ) && ({1'b0, slot_q} < 5'(count_q))
		&& (5'(slot_q) < 5'(LOG_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q        <= '0;
			gear_logged_q <= '0;
			wptr_q        <= '0;
			count_q       <= '0;
		end else if (cmd.exec) begin
			gear_q <= gear_nxt;
			if (wr_en) begin
				gear_logged_q <= gear_nxt;
				if (wptr_q == PTR_W'(LOG_DEPTH - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + PTR_W'(1);
				end
				if (count_q != CNT_W'(LOG_DEPTH)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			speed_q   <= (op_q == OP_SAMPLE) ? speed_nxt : 7'd0;
			written_q <= wr_en;
			valid_q   <= rd_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[wptr_q] <= word_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_word_q <= mem_q[slot_q[PTR_W-1:0]];
		end
	end

	assign current_gear   = gear_q;
	assign current_speed  = speed_q;
	assign record_written = written_q;
	assign record_valid   = valid_q;
	assign rec_hours      = valid_q ? rd_word_q[5:0]   : 6'd0;
	assign rec_minutes    = valid_q ? rd_word_q[13:6]  : 8'd0;
	assign rec_seconds    = valid_q ? rd_word_q[21:14] : 8'd0;
	assign rec_speed      = valid_q ? rd_word_q[28:22] : 7'd0;
	assign rec_gear       = valid_q ? rd_word_q[31:29] : 3'd0;
	assign stored_count   = 5'(count_q);
	assign next_slot      = 4'(wptr_q);

	`GERL_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(LOG_DEPTH), "record count above depth")
	`GERL_ASSERT(a_wptr_bound, clk, arst_n, 5'(wptr_q) < 5'(LOG_DEPTH), "write slot out of ring")
	`GERL_ASSERT_NEXT(a_logged_tracks, clk, arst_n, cmd.exec && wr_en, gear_logged_q == gear_q && count_q != '0, "logged gear not updated on record write")

endmodule

### hw/rtl/gear_event_ring_logger.sv
// Top level of the gear event ring logger: controller plus datapath.
// Each item passes through these steps: the cycle of its transfer in, at
// whose edge the item is captured and sample*100 formed; the execute step,
// which updates the gear, finishes the scaling and writes or reads the record
// ring (one write port, one read port); the response step, which offers the
// result, held until out_stall is low. A new item is taken only after the
// previous result has been transferred, so items do not overlap. No clearing
// pass after reset: record slots are only read once written.
module gear_event_ring_logger #(
	parameter int LOG_DEPTH = gerl_pkg::LOG_DEPTH_DEF,
	parameter int TOP_GEAR  = gerl_pkg::TOP_GEAR_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [1:0] key_event,
	input  logic [7:0] hours_bcd,
	input  logic [7:0] minutes_bcd,
	input  logic [7:0] seconds_bcd,
	input  logic [9:0] speed_sample,
	input  logic [3:0] read_slot,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] current_gear,
	output logic [6:0] current_speed,
	output logic       record_written,
	output logic       record_valid,
	output logic [5:0] rec_hours,
	output logic [7:0] rec_minutes,
	output logic [7:0] rec_seconds,
	output logic [6:0] rec_speed,
	output logic [2:0] rec_gear,
	output logic [4:0] stored_count,
	output logic [3:0] next_slot
);
	import gerl_pkg::*;

	cmd_t cmd;

	gerl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	gerl_dpath #(
		.LOG_DEPTH (LOG_DEPTH),
		.TOP_GEAR  (TOP_GEAR)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operation      (operation),
		.key_event      (key_event),
		.hours_bcd      (hours_bcd),
		.minutes_bcd    (minutes_bcd),
		.seconds_bcd    (seconds_bcd),
		.speed_sample   (speed_sample),
		.read_slot      (read_slot),
		.current_gear   (current_gear),
		.current_speed  (current_speed),
		.record_written (record_written),
		.record_valid   (record_valid),
		.rec_hours      (rec_hours),
		.rec_minutes    (rec_minutes),
		.rec_seconds    (rec_seconds),
		.rec_speed      (rec_speed),
		.rec_gear       (rec_gear),
		.stored_count   (stored_count),
		.next_slot      (next_slot)
	);

endmodule
